>>> sv/fpa_pkg.sv
// shared constants, types and saturation helper for the fixed-point alu
package fpa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int WORD_W    = 32;
  localparam int NUM_W     = WORD_W + FRAC_BITS;
  localparam int DIV_STEPS = NUM_W;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int OP_W      = 4;

  localparam logic [OP_W-1:0] OP_ADD    = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB    = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL    = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV    = 4'd3;
  localparam logic [OP_W-1:0] OP_MIN    = 4'd4;
  localparam logic [OP_W-1:0] OP_MAX    = 4'd5;
  localparam logic [OP_W-1:0] OP_INC    = 4'd6;
  localparam logic [OP_W-1:0] OP_DEC    = 4'd7;
  localparam logic [OP_W-1:0] OP_TO_INT = 4'd8;

  localparam logic [WORD_W-1:0] MAX_POS = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] MIN_NEG = {1'b1, {(WORD_W-1){1'b0}}};

  // fields that ride alongside the divider
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic              lt;
    logic              eq;
    logic              gt;
    logic              neg;
    logic              a_neg;
    logic              bz;
    logic [WORD_W-1:0] res;
    logic              ovf;
  } side_t;

  typedef struct packed {
    logic [WORD_W-1:0] rem;
    logic [NUM_W-1:0]  num;
    logic [WORD_W-1:0] mb;
    side_t             side;
  } div_t;

  // sign and magnitude to saturated word, returns {ovf, word}
  function automatic logic [WORD_W:0] sat_mag(input logic neg,
                                              input logic [PROD_W-1:0] mag);
    logic [WORD_W-1:0] low;
    logic [WORD_W:0]   r;
    low = mag[WORD_W-1:0];
    if (neg) begin
      if (mag > {{WORD_W{1'b0}}, MIN_NEG}) r = {1'b1, MIN_NEG};
      else r = {1'b0, -low};
    end else begin
      if (mag > {{WORD_W{1'b0}}, MAX_POS}) r = {1'b1, MAX_POS};
      else r = {1'b0, low};
    end
    return r;
  endfunction

endpackage

>>> sv/fpa_if.sv
// handshake channel interfaces for operation items and result items
interface fpa_in_if;
  import fpa_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [WORD_W-1:0] operand_a;
  logic signed [WORD_W-1:0] operand_b;
  modport source(output valid, operation, operand_a, operand_b, input ready);
  modport sink(input valid, operation, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if;
  import fpa_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] result_value;
  logic                     a_less;
  logic                     a_equal;
  logic                     a_greater;
  logic                     overflow;
  logic                     divide_by_zero;
  modport source(output valid, result_value, a_less, a_equal, a_greater, overflow,
                 divide_by_zero, input ready);
  modport sink(input valid, result_value, a_less, a_equal, a_greater, overflow,
               divide_by_zero, output ready);
endinterface

>>> sv/fixed_point_alu_top.sv
// top level of the pipelined 24.8 fixed-point alu
// usage:
//   in_ch carries one operation item (operation, operand_a, operand_b) and
//   out_ch carries one result item (value, compare flags, overflow, divide
//   by zero) for every item taken, in the same order
//   an item is taken on a rising edge with valid and ready both high
// stages: one entry stage, one restoring divider stage per quotient bit and
//   one result stage
// throughput: one item per cycle unless stalled; the chain of divider stages
//   sets the depth and every operation walks the full chain so results stay in order
// the multiplier sits beside the first two divider stages and its result
//   joins the travelling fields ahead of the third
// reset: synchronous, active low; clears all stage valid bits, no result
//   is pending afterwards
// stall: when a result waits unread the whole pipeline holds, in_ch.ready
//   drops in the same cycle and no item is lost or repeated
module fixed_point_alu_top import fpa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  fpa_in_if.sink     in_ch,
  fpa_out_if.source  out_ch
);

  logic              adv;
  logic              vld [0:DIV_STEPS];
  div_t              dq  [0:DIV_STEPS];
  logic [WORD_W-1:0] ma;
  logic [WORD_W-1:0] mul_res;
  logic              mul_ovf;
  div_t              merged;
  logic              out_valid;

  // pipeline moves whenever the output register is free or being read
  assign adv         = !out_valid || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = out_valid;

  fpa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_ch.valid),
    .op       (in_ch.operation),
    .a        (in_ch.operand_a),
    .b        (in_ch.operand_b),
    .valid_r  (vld[0]),
    .div_r    (dq[0]),
    .ma_r     (ma)
  );

  fpa_mul u_mul (
    .clk   (clk),
    .adv   (adv),
    .ma    (ma),
    .mb    (dq[0].mb),
    .neg   (dq[0].side.neg),
    .res_r (mul_res),
    .ovf_r (mul_ovf)
  );

  // product lines up with the item leaving the second divider stage
  always_comb begin
    merged = dq[2];
    if (dq[2].side.op == OP_MUL) begin
      merged.side.res = mul_res;
      merged.side.ovf = mul_ovf;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    div_t step_in;
    if (k == 2) begin : g_merge
      assign step_in = merged;
    end else begin : g_plain
      assign step_in = dq[k];
    end
    fpa_div_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .valid_in (vld[k]),
      .d_in     (step_in),
      .valid_r  (vld[k+1]),
      .d_r      (dq[k+1])
    );
  end

  fpa_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .valid_in (vld[DIV_STEPS]),
    .d_in     (dq[DIV_STEPS]),
    .valid_r  (out_valid),
    .res_r    (out_ch.result_value),
    .lt_r     (out_ch.a_less),
    .eq_r     (out_ch.a_equal),
    .gt_r     (out_ch.a_greater),
    .ovf_r    (out_ch.overflow),
    .dz_r     (out_ch.divide_by_zero)
  );

endmodule

>>> sv/fpa_front.sv
// entry stage: compare, magnitudes, simple operations and divider set-up
module fpa_front import fpa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic [OP_W-1:0]          op,
  input  logic signed [WORD_W-1:0] a,
  input  logic signed [WORD_W-1:0] b,
  output logic                     valid_r,
  output div_t                     div_r,
  output logic [WORD_W-1:0]        ma_r
);

  function automatic logic [WORD_W:0] sat_wide(input logic [WORD_W:0] s);
    logic [WORD_W:0] r;
    if (s[WORD_W] != s[WORD_W-1]) r = {1'b1, (s[WORD_W] ? MIN_NEG : MAX_POS)};
    else r = {1'b0, s[WORD_W-1:0]};
    return r;
  endfunction

  logic [WORD_W-1:0] ma, mb, tq;
  logic [WORD_W:0]   ae, be, sv;
  side_t             side;
  div_t              div_nxt;

  always_comb begin
    ae = {a[WORD_W-1], a};
    be = {b[WORD_W-1], b};
    ma = a[WORD_W-1] ? -a : a;
    mb = b[WORD_W-1] ? -b : b;
    tq = ma >> FRAC_BITS;
    side.op    = op;
    side.lt    = a < b;
    side.eq    = a == b;
    side.gt    = a > b;
    side.neg   = a[WORD_W-1] ^ b[WORD_W-1];
    side.a_neg = a[WORD_W-1];
    side.bz    = b == '0;
    sv = '0;
    case (op)
      OP_ADD:    sv = sat_wide(ae + be);
      OP_SUB:    sv = sat_wide(ae - be);
      OP_INC:    sv = sat_wide(ae + (WORD_W+1)'(1));
      OP_DEC:    sv = sat_wide(ae - (WORD_W+1)'(1));
      OP_MIN:    sv = {1'b0, (side.lt ? a : b)};
      OP_MAX:    sv = {1'b0, (side.gt ? a : b)};
      OP_TO_INT: sv = {1'b0, (a[WORD_W-1] ? -tq : tq)};
      default:   sv = '0;
    endcase
    side.ovf = sv[WORD_W];
    side.res = sv[WORD_W-1:0];
    div_nxt.rem  = '0;
    div_nxt.num  = {ma, {FRAC_BITS{1'b0}}};
    div_nxt.mb   = mb;
    div_nxt.side = side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_r <= div_nxt;
      ma_r  <= ma;
    end
  end

endmodule

>>> sv/fpa_mul.sv
// two-stage magnitude multiplier with round half away and saturation
module fpa_mul import fpa_pkg::*; (
  input  logic              clk,
  input  logic              adv,
  input  logic [WORD_W-1:0] ma,
  input  logic [WORD_W-1:0] mb,
  input  logic              neg,
  output logic [WORD_W-1:0] res_r,
  output logic              ovf_r
);

  logic [PROD_W-1:0] prod_r, rnd;
  logic              neg_r;
  logic [WORD_W:0]   sat;

  always_comb begin
    rnd = (prod_r + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    sat = sat_mag(neg_r, rnd);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= PROD_W'(ma) * PROD_W'(mb);
      neg_r  <= neg;
      res_r  <= sat[WORD_W-1:0];
      ovf_r  <= sat[WORD_W];
    end
  end

endmodule

>>> sv/fpa_div_step.sv
// one restoring division step, one quotient bit per stage
module fpa_div_step import fpa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic valid_in,
  input  div_t d_in,
  output logic valid_r,
  output div_t d_r
);

  logic [WORD_W:0] t;
  logic            ge;
  div_t            d_nxt;

  always_comb begin
    t  = {d_in.rem, d_in.num[NUM_W-1]};
    ge = t >= {1'b0, d_in.mb};
    d_nxt      = d_in;
    d_nxt.rem  = ge ? WORD_W'(t - {1'b0, d_in.mb}) : t[WORD_W-1:0];
    d_nxt.num  = {d_in.num[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r <= d_nxt;
    end
  end

endmodule

>>> sv/fpa_back.sv
// result stage: quotient rounding, zero divisor and output register
module fpa_back import fpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              valid_in,
  input  div_t              d_in,
  output logic              valid_r,
  output logic [WORD_W-1:0] res_r,
  output logic              lt_r,
  output logic              eq_r,
  output logic              gt_r,
  output logic              ovf_r,
  output logic              dz_r
);

  logic             rnd;
  logic [NUM_W:0]   q;
  logic [WORD_W:0]  sat;
  logic [WORD_W-1:0] res_nxt;
  logic             ovf_nxt, dz_nxt;

  always_comb begin
    rnd = {d_in.rem, 1'b0} >= {1'b0, d_in.mb};
    q   = {1'b0, d_in.num} + (NUM_W+1)'(rnd);
    sat = sat_mag(d_in.side.neg, {{(PROD_W-NUM_W-1){1'b0}}, q});
    res_nxt = d_in.side.res;
    ovf_nxt = d_in.side.ovf;
    dz_nxt  = 1'b0;
    if (d_in.side.op == OP_DIV) begin
      if (d_in.side.bz) begin
        res_nxt = d_in.side.a_neg ? MIN_NEG : MAX_POS;
        ovf_nxt = 1'b0;
        dz_nxt  = 1'b1;
      end else begin
        res_nxt = sat[WORD_W-1:0];
        ovf_nxt = sat[WORD_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
      lt_r  <= d_in.side.lt;
      eq_r  <= d_in.side.eq;
      gt_r  <= d_in.side.gt;
      ovf_r <= ovf_nxt;
      dz_r  <= dz_nxt;
    end
  end

endmodule

>>> test/tb_top.sv
// self-checking testbench for the pipelined 24.8 fixed-point alu
module tb_top;
  import fpa_pkg::*;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
  } op_item_t;

  typedef struct {
    logic [WORD_W-1:0] value;
    logic              lt;
    logic              eq;
    logic              gt;
    logic              ovf;
    logic              dz;
  } alu_result_t;

  localparam int LATENCY = DIV_STEPS + 2;

  logic clk;
  logic rst_n;

  fpa_in_if  in_ch();
  fpa_out_if out_ch();

  fixed_point_alu_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  op_item_t    pending_ops[$];
  alu_result_t expected_results[$];
  int          error_count;
  int          result_count;
  int          hold_off_cycles;
  bit          sender_pause;
  bit          stimulus_done;
  bit          idle_enable;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // build a signed word from sign and magnitude, saturating at the limits
  function automatic logic [WORD_W:0] pack_signed(input bit neg, input logic [63:0] mag);
    if (neg) begin
      if (mag > 64'd2147483648) return {1'b1, MIN_NEG};
      return {1'b0, 32'(-mag)};
    end
    if (mag > 64'd2147483647) return {1'b1, MAX_POS};
    return {1'b0, mag[31:0]};
  endfunction

  // clamp a wide signed sum to the word range
  function automatic logic [WORD_W:0] clamp_word(input longint x);
    if (x > 64'sd2147483647) return {1'b1, MAX_POS};
    if (x < -64'sd2147483648) return {1'b1, MIN_NEG};
    return {1'b0, 32'(x)};
  endfunction

  // predicted result of one operation item
  function automatic alu_result_t alu_predict(input op_item_t it);
    alu_result_t r;
    longint      a;
    longint      b;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] q;
    logic [WORD_W:0] s;
    bit          neg;
    a   = it.a;
    b   = it.b;
    ma  = (a < 0) ? 64'(-a) : 64'(a);
    mb  = (b < 0) ? 64'(-b) : 64'(b);
    neg = (a < 0) != (b < 0);
    s   = '0;
    r.dz = 1'b0;
    case (it.op)
      OP_ADD: s = clamp_word(a + b);
      OP_SUB: s = clamp_word(a - b);
      OP_MUL: begin
        q = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        s = pack_signed(neg, q);
      end
      OP_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
          s = {1'b0, (a < 0) ? MIN_NEG : MAX_POS};
        end else begin
          q = (2 * (ma << FRAC_BITS) + mb) / (2 * mb);
          s = pack_signed(neg, q);
        end
      end
      OP_MIN: s = {1'b0, (a < b) ? it.a : it.b};
      OP_MAX: s = {1'b0, (a > b) ? it.a : it.b};
      OP_INC: s = clamp_word(a + 1);
      OP_DEC: s = clamp_word(a - 1);
      OP_TO_INT: begin
        q = ma >> FRAC_BITS;
        s = {1'b0, (a < 0) ? 32'(-q) : q[31:0]};
      end
      default: s = '0;
    endcase
    r.value = s[WORD_W-1:0];
    r.ovf   = s[WORD_W];
    r.lt    = a < b;
    r.eq    = a == b;
    r.gt    = a > b;
    return r;
  endfunction

  // operand picked to hit edges often: extremes, small values, exact powers
  function automatic logic [WORD_W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return MAX_POS - $urandom_range(0, 2);
      1: return MIN_NEG + $urandom_range(0, 2);
      2: return 32'($urandom_range(0, 8)) - 32'd4;
      3: return 32'($urandom_range(0, 4096)) - 32'd2048;
      4: return 32'($urandom_range(0, 1)) ? (32'd1 << $urandom_range(0, 30))
                                          : -(32'd1 << $urandom_range(0, 31));
      5: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
      default: return $urandom;
    endcase
  endfunction

  function automatic op_item_t make_op(input logic [OP_W-1:0] op,
                                       input logic [WORD_W-1:0] a,
                                       input logic [WORD_W-1:0] b);
    op_item_t it;
    it.op = op;
    it.a  = a;
    it.b  = b;
    return it;
  endfunction

  // stimulus: directed corners first, then random items
  initial begin
    op_item_t it;
    int       op_sel;
    rst_n = 1'b0;
    stimulus_done = 1'b0;
    sender_pause = 1'b0;
    idle_enable = 1'b1;
    hold_off_cycles = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // every operation at the extremes, including the unused codes
    for (int op = 0; op < 16; op++) begin
      pending_ops.push_back(make_op(OP_W'(op), MAX_POS, MAX_POS));
    end
    pending_ops.push_back(make_op(OP_ADD, MIN_NEG, MIN_NEG));
    pending_ops.push_back(make_op(OP_SUB, MIN_NEG, MAX_POS));
    pending_ops.push_back(make_op(OP_MUL, MIN_NEG, 32'hFFFF_FF00));
    pending_ops.push_back(make_op(OP_MUL, 32'h0000_0080, 32'h0000_0001));
    // zero divisor with dividend of each sign
    pending_ops.push_back(make_op(OP_DIV, 32'd0, 32'd0));
    pending_ops.push_back(make_op(OP_DIV, MIN_NEG, 32'd0));
    pending_ops.push_back(make_op(OP_DIV, MIN_NEG, 32'hFFFF_FFFF));
    pending_ops.push_back(make_op(OP_INC, MAX_POS, 32'd0));
    pending_ops.push_back(make_op(OP_DEC, MIN_NEG, 32'd0));
    pending_ops.push_back(make_op(OP_TO_INT, 32'hFFFF_FE80, 32'd0));

    // first pressure phase: sink stalls while items keep coming
    for (int i = 0; i < 120; i++) begin
      pending_ops.push_back(make_op(OP_W'($urandom_range(0, 8)), pick_operand(),
                                    pick_operand()));
    end
    hold_off_cycles = 150;

    for (int i = 0; i < 1400; i++) begin
      op_sel = $urandom_range(0, 19);
      it.op  = (op_sel < 18) ? OP_W'(op_sel % 9) : OP_W'($urandom_range(9, 15));
      it.a   = pick_operand();
      it.b   = ($urandom_range(0, 7) == 0) ? it.a : pick_operand();
      if (it.op == OP_DIV && $urandom_range(0, 9) == 0) it.b = '0;
      pending_ops.push_back(it);
      // second pressure phase: sender waits for the pipeline to drain
      if (i == 600) begin
        wait (pending_ops.size() == 0 && !in_ch.valid && expected_results.size() == 0);
        sender_pause = 1'b1;
        repeat (20) @(posedge clk);
        sender_pause = 1'b0;
      end
      // stretch with no idling at all, held while these items drain
      if (i == 900) begin
        wait (pending_ops.size() == 0);
        idle_enable = 1'b0;
      end
      if (i == 1200) begin
        wait (pending_ops.size() == 0);
        idle_enable = 1'b1;
      end
    end
    stimulus_done = 1'b1;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.operation <= '0;
      in_ch.operand_a <= '0;
      in_ch.operand_b <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(alu_predict(make_op(in_ch.operation, in_ch.operand_a,
                                                       in_ch.operand_b)));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_ops.size() > 0 && !sender_pause &&
            !(idle_enable && $urandom_range(0, 99) < 25)) begin
          op_item_t it;
          it = pending_ops.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.operation <= it.op;
          in_ch.operand_a <= it.a;
          in_ch.operand_b <= it.b;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // sink ready, with random stalls and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_ch.ready <= !(idle_enable && $urandom_range(0, 99) < 25);
    end
  end

  // monitor: compare each result item with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result item value=%h", $time, out_ch.result_value);
        error_count <= error_count + 1;
      end else begin
        alu_result_t e;
        e = expected_results.pop_front();
        result_count <= result_count + 1;
        if (out_ch.result_value !== e.value || out_ch.a_less !== e.lt ||
            out_ch.a_equal !== e.eq || out_ch.a_greater !== e.gt ||
            out_ch.overflow !== e.ovf || out_ch.divide_by_zero !== e.dz) begin
          $display("%0t: mismatch expected val=%h lt=%b eq=%b gt=%b ovf=%b dz=%b",
                   $time, e.value, e.lt, e.eq, e.gt, e.ovf, e.dz);
          $display("%0t:          actual   val=%h lt=%b eq=%b gt=%b ovf=%b dz=%b",
                   $time, out_ch.result_value, out_ch.a_less, out_ch.a_equal,
                   out_ch.a_greater, out_ch.overflow, out_ch.divide_by_zero);
          error_count <= error_count + 1;
        end
      end
    end
  end

  initial begin
    error_count  = 0;
    result_count = 0;
  end

  // end of run once everything has drained
  initial begin
    wait (stimulus_done && pending_ops.size() == 0 && !in_ch.valid &&
          expected_results.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered all operation codes incl. unused ones, saturation and zero divisors");
    $display("checked %0d result items under random and long output stalls", result_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("timeout waiting for result items");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> sim.f
sv/fpa_pkg.sv
sv/fpa_if.sv
sv/fpa_front.sv
sv/fpa_mul.sv
sv/fpa_div_step.sv
sv/fpa_back.sv
sv/fixed_point_alu_top.sv
test/tb_top.sv
